// ===== rtl/core/ccd_pkg.sv =====
// ccd_pkg: field widths, configuration register codes and the request type of
// the shared divide / square-root unit of the cusum change detector.
// No dependencies.
`timescale 1ns / 1ps

package ccd_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int POS_W       = 32;
    localparam int STAT_W      = 40;
    localparam int K_W         = 32;
    localparam int H_W         = 32;
    localparam int HOLD_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int OPND_W      = 64;
    localparam int ROOT_W      = 32;
    localparam int STEP_W      = 7;
    localparam int ALLOW_W     = 42;
    localparam int CALC_W      = 44;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWANCE_K = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF     = 2'd2;

    localparam logic ITER_DIV  = 1'b0;
    localparam logic ITER_SQRT = 1'b1;

    localparam logic [STEP_W-1:0] STEPS_DIV32 = 7'd32;
    localparam logic [STEP_W-1:0] STEPS_DIV64 = 7'd64;
    localparam logic [STEP_W-1:0] STEPS_SQRT  = 7'd32;

    typedef struct packed {
        logic              start;
        logic              op_sqrt;
        logic [STEP_W-1:0] steps;
    } ccd_iter_req_t;

endpackage

// ===== rtl/core/ccd_channels.sv =====
// ccd_in_if / ccd_out_if: valid-ready channels for sample beats and result beats
// depends on ccd_pkg
`timescale 1ns / 1ps

interface ccd_in_if import ccd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       new_sequence;

    modport source (output valid, output sample_value, output new_sequence, input ready);
    modport sink   (input valid, input sample_value, input new_sequence, output ready);
endinterface

interface ccd_out_if import ccd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              change_found;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] upper_stat;
    logic [STAT_W-1:0] lower_stat;

    modport source (output valid, output change_found, output position,
                    output upper_stat, output lower_stat, input ready);
    modport sink   (input valid, input change_found, input position,
                    input upper_stat, input lower_stat, output ready);
endinterface

// ===== rtl/core/ccd_iter_unit.sv =====
// ccd_iter_unit: shared restoring divider and digit-by-digit square root,
// one quotient or root bit per cycle over a single subtractor
// depends on ccd_pkg
`timescale 1ns / 1ps

module ccd_iter_unit import ccd_pkg::*; #(
    parameter int DIV_W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ccd_iter_req_t       req,
    input  logic [OPND_W-1:0]   operand,
    input  logic [DIV_W-1:0]    divisor,
    output logic                done,
    output logic [OPND_W-1:0]   result
);

    localparam int REM_W  = (DIV_W > ROOT_W + 1) ? DIV_W : ROOT_W + 1;
    localparam int PART_W = REM_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic              sqrt_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [OPND_W-1:0] work_reg;
    logic [OPND_W-1:0] acc_reg;
    logic [REM_W-1:0]  rem_reg;

    logic [PART_W-1:0] part;
    logic [PART_W-1:0] trial;
    logic [PART_W:0]   diff;
    logic              fits;

    always_comb
    begin
        if (sqrt_reg)
        begin
            part  = {rem_reg, work_reg[OPND_W-1:OPND_W-2]};
            trial = {{(REM_W-ROOT_W){1'b0}}, acc_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            part  = {1'b0, rem_reg, work_reg[OPND_W-1]};
            trial = {{(PART_W-DIV_W){1'b0}}, divisor};
        end
        diff = {1'b0, part} - {1'b0, trial};
        fits = ~diff[PART_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= ITER_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= req.op_sqrt;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= operand;
            acc_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[REM_W-1:0] : part[REM_W-1:0];
            acc_reg  <= {acc_reg[OPND_W-2:0], fits};
            work_reg <= sqrt_reg ? {work_reg[OPND_W-3:0], 2'b00}
                                 : {work_reg[OPND_W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/core/cusum_change_detector.sv =====
// cusum_change_detector: two-sided tabular cusum over signed fixed-point samples
// depends on ccd_pkg, ccd_in_if / ccd_out_if and ccd_iter_unit
// ----------------------------------------------------------------------------
// samples carries one sample beat (sample_value, new_sequence); results carries
// one result beat per sample (change_found, position, upper_stat, lower_stat).
// Configuration is written through cfg_we / cfg_index / cfg_data while idle,
// a rule for the user that the block does not enforce: index 0 allowance k,
// 1 decision threshold, 2 holdoff distance. One sample is worked on at a time;
// samples.ready is high only between items, so no new sample is taken until
// the work on the last one is done. Every division and the square root run on
// one shared unit, one bit a cycle: the mean update takes a 32-step division,
// and an armed sample adds a 64-step variance division and a 32-step square
// root. The next sample is accepted at the edge where the result can first be
// taken. The result waits in an output register; while results is stalled
// a finished item holds there and the next sample is accepted, but its own
// result waits until the register is taken.
// Reset loads the default configuration and clears the running statistics;
// there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cusum_change_detector import ccd_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ccd_in_if.sink                samples,
    ccd_out_if.source             results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [K_W-1:0] K_RESET = K_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic [H_W-1:0] H_RESET = H_W'(((64'd801 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [OPND_W-1:0] ALLOW_CAP = 64'd1 << (ALLOW_W - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV1   = 4'd1;
    localparam logic [3:0] S_WAIT1  = 4'd2;
    localparam logic [3:0] S_DELTA2 = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_ACC    = 4'd5;
    localparam logic [3:0] S_DIV2   = 4'd6;
    localparam logic [3:0] S_WAIT2  = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_WAIT3  = 4'd9;
    localparam logic [3:0] S_MUL2   = 4'd10;
    localparam logic [3:0] S_ALLOW  = 4'd11;
    localparam logic [3:0] S_UPD    = 4'd12;
    localparam logic [3:0] S_DECIDE = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;

    logic [3:0]             state_reg;

    logic [K_W-1:0]         k_reg;
    logic [H_W-1:0]         h_reg;
    logic [HOLD_W-1:0]      hold_reg;

    logic [COUNT_WIDTH-1:0] idx_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] armed_reg;
    logic [SAMPLE_W-1:0]    mean_reg;
    logic [OPND_W-1:0]      ssd_reg;
    logic [STAT_W-1:0]      up_reg;
    logic [STAT_W-1:0]      lo_reg;

    logic [SAMPLE_W-1:0]    x_reg;
    logic [SAMPLE_W-1:0]    dabs_reg;
    logic                   dneg_reg;
    logic [SAMPLE_W:0]      d_reg;
    logic [SAMPLE_W-1:0]    d2abs_reg;
    logic [OPND_W-1:0]      mul_reg;
    logic [ALLOW_W-1:0]     allow_reg;

    logic                   pend_found_reg;
    logic [STAT_W-1:0]      pend_up_reg;
    logic [STAT_W-1:0]      pend_lo_reg;

    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic [STAT_W-1:0]      out_up_reg;
    logic [STAT_W-1:0]      out_lo_reg;

    ccd_iter_req_t          iter_req;
    logic [OPND_W-1:0]      iter_operand;
    logic                   iter_done;
    logic [OPND_W-1:0]      iter_result;

    logic [SAMPLE_W:0]      delta;
    logic [SAMPLE_W-1:0]    delta_abs;
    logic [SAMPLE_W+1:0]    mean_sum;
    logic [OPND_W:0]        ssd_sum;
    logic [SAMPLE_W-1:0]    mul_a;
    logic [SAMPLE_W-1:0]    mul_b;
    logic [OPND_W-1:0]      allow_shift;
    logic [ALLOW_W-1:0]     allow_next;
    logic [CALC_W-1:0]      d_ext;
    logic [CALC_W-1:0]      up_sum;
    logic [CALC_W-1:0]      lo_sum;
    logic [COUNT_WIDTH:0]   hold_sum;
    logic [COUNT_WIDTH-1:0] armed_next;
    logic [COUNT_WIDTH-1:0] idx_inc;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH+POS_W-1:0] pos_wide;
    logic                   accept;
    logic                   out_free;
    logic                   hit;

    function automatic logic [STAT_W-1:0] clamp_stat(input logic [CALC_W-1:0] s);
        logic [STAT_W-1:0] r;
        begin
            if (s[CALC_W-1])
                r = '0;
            else if (s[CALC_W-2:STAT_W] != '0)
                r = '1;
            else
                r = s[STAT_W-1:0];
            return r;
        end
    endfunction

    ccd_iter_unit #(
        .DIV_W (COUNT_WIDTH)
    ) u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (iter_req),
        .operand (iter_operand),
        .divisor (cnt_reg),
        .done    (iter_done),
        .result  (iter_result)
    );

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        delta       = {x_reg[SAMPLE_W-1], x_reg} - {mean_reg[SAMPLE_W-1], mean_reg};
        delta_abs   = delta[SAMPLE_W] ? SAMPLE_W'(-delta) : delta[SAMPLE_W-1:0];
        mean_sum    = {{2{mean_reg[SAMPLE_W-1]}}, mean_reg}
                    + (dneg_reg ? -{2'b00, iter_result[SAMPLE_W-1:0]}
                                : {2'b00, iter_result[SAMPLE_W-1:0]});
        ssd_sum     = {1'b0, ssd_reg} + {1'b0, mul_reg};
        mul_a       = (state_reg == S_MUL2) ? k_reg : dabs_reg;
        mul_b       = (state_reg == S_MUL2) ? iter_result[SAMPLE_W-1:0] : d2abs_reg;
        allow_shift = mul_reg >> FRAC_BITS;
        allow_next  = (allow_shift > ALLOW_CAP) ? ALLOW_CAP[ALLOW_W-1:0]
                                                : allow_shift[ALLOW_W-1:0];
        d_ext       = {{(CALC_W-SAMPLE_W-1){d_reg[SAMPLE_W]}}, d_reg};
        up_sum      = {{(CALC_W-STAT_W){1'b0}}, up_reg} + d_ext
                    - {{(CALC_W-ALLOW_W){1'b0}}, allow_reg};
        lo_sum      = {{(CALC_W-STAT_W){1'b0}}, lo_reg} - d_ext
                    - {{(CALC_W-ALLOW_W){1'b0}}, allow_reg};
        hold_sum    = {1'b0, idx_reg} + (COUNT_WIDTH+1)'(hold_reg);
        armed_next  = hold_sum[COUNT_WIDTH] ? COUNT_MAX : hold_sum[COUNT_WIDTH-1:0];
        idx_inc     = (idx_reg == COUNT_MAX) ? idx_reg : idx_reg + 1'b1;
        cnt_inc     = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        pos_wide    = {{POS_W{1'b0}}, idx_reg};
        hit         = (up_reg > {{(STAT_W-H_W){1'b0}}, h_reg})
                   || (lo_reg > {{(STAT_W-H_W){1'b0}}, h_reg});
    end

    // issue requests to the shared unit
    always_comb
    begin
        iter_req     = '0;
        iter_operand = '0;
        unique case (state_reg)
            S_DIV1:
            begin
                iter_req.start   = 1'b1;
                iter_req.op_sqrt = ITER_DIV;
                iter_req.steps   = STEPS_DIV32;
                iter_operand     = {delta_abs, {(OPND_W-SAMPLE_W){1'b0}}};
            end
            S_DIV2:
            begin
                iter_req.start   = 1'b1;
                iter_req.op_sqrt = ITER_DIV;
                iter_req.steps   = STEPS_DIV64;
                iter_operand     = ssd_reg;
            end
            S_SQRT:
            begin
                iter_req.start   = 1'b1;
                iter_req.op_sqrt = ITER_SQRT;
                iter_req.steps   = STEPS_SQRT;
                iter_operand     = iter_result;
            end
            default:
            begin
                iter_req     = '0;
                iter_operand = '0;
            end
        endcase
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= K_RESET;
            h_reg    <= H_RESET;
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALLOWANCE_K: k_reg    <= cfg_data[K_W-1:0];
                CFG_THRESHOLD:   h_reg    <= cfg_data[H_W-1:0];
                CFG_HOLDOFF:     hold_reg <= cfg_data[HOLD_W-1:0];
                default:         k_reg    <= k_reg;
            endcase
        end
    end

    // sequencer and running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            armed_reg     <= COUNT_WIDTH'(HOLD_RESET);
            mean_reg      <= '0;
            ssd_reg       <= '0;
            up_reg        <= '0;
            lo_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (samples.new_sequence)
                        begin
                            idx_reg   <= COUNT_WIDTH'(1);
                            cnt_reg   <= COUNT_WIDTH'(1);
                            armed_reg <= COUNT_WIDTH'(hold_reg);
                            mean_reg  <= '0;
                            ssd_reg   <= '0;
                            up_reg    <= '0;
                            lo_reg    <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_inc;
                            cnt_reg <= cnt_inc;
                        end
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    state_reg <= S_WAIT1;
                end
                S_WAIT1:
                begin
                    if (iter_done)
                    begin
                        mean_reg  <= mean_sum[SAMPLE_W-1:0];
                        state_reg <= S_DELTA2;
                    end
                end
                S_DELTA2:
                begin
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    ssd_reg   <= ssd_sum[OPND_W] ? '1 : ssd_sum[OPND_W-1:0];
                    state_reg <= (idx_reg > armed_reg) ? S_DIV2 : S_EMIT;
                end
                S_DIV2:
                begin
                    state_reg <= S_WAIT2;
                end
                S_WAIT2:
                begin
                    if (iter_done)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    state_reg <= S_WAIT3;
                end
                S_WAIT3:
                begin
                    if (iter_done)
                        state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_ALLOW;
                end
                S_ALLOW:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    up_reg    <= clamp_stat(up_sum);
                    lo_reg    <= clamp_stat(lo_sum);
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (hit)
                    begin
                        armed_reg <= armed_next;
                        cnt_reg   <= '0;
                        mean_reg  <= '0;
                        ssd_reg   <= '0;
                        up_reg    <= '0;
                        lo_reg    <= '0;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= samples.sample_value;

        if (state_reg == S_DIV1)
        begin
            dabs_reg <= delta_abs;
            dneg_reg <= delta[SAMPLE_W];
        end

        if (state_reg == S_DELTA2)
        begin
            d_reg     <= delta;
            d2abs_reg <= delta_abs;
        end

        if (state_reg == S_MUL1 || state_reg == S_MUL2)
            mul_reg <= mul_a * mul_b;

        if (state_reg == S_ALLOW)
            allow_reg <= allow_next;

        if (state_reg == S_ACC)
        begin
            pend_found_reg <= 1'b0;
            pend_up_reg    <= up_reg;
            pend_lo_reg    <= lo_reg;
        end

        if (state_reg == S_DECIDE)
        begin
            pend_found_reg <= hit;
            pend_up_reg    <= up_reg;
            pend_lo_reg    <= lo_reg;
        end

        if (state_reg == S_EMIT && out_free)
        begin
            out_found_reg <= pend_found_reg;
            out_pos_reg   <= pos_wide[POS_W-1:0];
            out_up_reg    <= pend_up_reg;
            out_lo_reg    <= pend_lo_reg;
        end
    end

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.change_found = out_found_reg;
    assign results.position     = out_pos_reg;
    assign results.upper_stat   = out_up_reg;
    assign results.lower_stat   = out_lo_reg;

endmodule

// ===== bench/tb_cusum_change_detector.sv =====
// tb_cusum_change_detector: self-checking bench for the cusum change detector,
// random and directed sample beats checked against a cycle-free cusum predictor
// depends on ccd_pkg, ccd_in_if / ccd_out_if and cusum_change_detector
`timescale 1ns / 1ps

module tb_cusum_change_detector;
    import ccd_pkg::*;

    localparam int COUNT_W = 32;
    localparam int RUN_LIMIT = 1_200_000;
    localparam int END_WAIT = 200;
    localparam int HOLD_AT = 120;
    localparam int HOLD_SPAN = 800;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [K_W-1:0] K_DEFAULT = 32'd16384;
    localparam logic [H_W-1:0] H_DEFAULT = 32'd524943;
    localparam logic [HOLD_W-1:0] HOLD_DEFAULT = 10'd3;
    localparam logic [63:0] ALLOW_CAP = 64'd1 << 41;
    localparam longint STAT_CAP = (64'sd1 <<< STAT_W) - 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       restart;
    } sample_beat_t;

    typedef struct packed {
        logic              change_found;
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] upper_stat;
        logic [STAT_W-1:0] lower_stat;
    } cusum_verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccd_in_if  smp ();
    ccd_out_if res ();

    cusum_change_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (smp),
        .results   (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of configuration and running statistics
    logic [K_W-1:0]        k_cfg = K_DEFAULT;
    logic [H_W-1:0]        h_cfg = H_DEFAULT;
    logic [HOLD_W-1:0]     hold_cfg = HOLD_DEFAULT;
    logic [COUNT_W-1:0]    seen_count = '0;
    logic [COUNT_W-1:0]    run_len = '0;
    logic signed [31:0]    mean_q = '0;
    logic [63:0]           dev_sum = '0;
    logic [STAT_W-1:0]     cusum_up = '0;
    logic [STAT_W-1:0]     cusum_dn = '0;
    logic [COUNT_W-1:0]    arm_pos = COUNT_W'(HOLD_DEFAULT);

    sample_beat_t   sample_backlog[$];
    cusum_verdict_t cusum_due[$];
    sample_beat_t   next_beat;
    cusum_verdict_t want;

    int  mismatch_count = 0;
    int  accepted_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  backpressure_left = 0;
    bit  hold_done = 1'b0;
    bit  steady_tail = 1'b0;

    function automatic logic [STAT_W-1:0] clamp_stat(longint s);
        if (s < 0)
            return '0;
        if (s > STAT_CAP)
            return '1;
        return s[STAT_W-1:0];
    endfunction

    function automatic cusum_verdict_t advance_cusum(logic signed [SAMPLE_W-1:0] x,
                                                     logic restart);
        longint xs, delta, delta2, d, s_up, s_dn;
        logic [63:0] mag1, mag2, prod, var_q, root, trial, allow;
        logic [64:0] acc;
        logic [COUNT_W:0] next_arm;
        cusum_verdict_t r;

        if (restart)
        begin
            seen_count = '0;
            run_len = '0;
            mean_q = '0;
            dev_sum = '0;
            cusum_up = '0;
            cusum_dn = '0;
            arm_pos = COUNT_W'(hold_cfg);
        end
        if (seen_count != '1)
            seen_count = seen_count + 1'b1;
        if (run_len != '1)
            run_len = run_len + 1'b1;

        xs = x;
        delta = xs - mean_q;
        mean_q = mean_q + delta / longint'(run_len);
        delta2 = xs - mean_q;
        mag1 = delta < 0 ? -delta : delta;
        mag2 = delta2 < 0 ? -delta2 : delta2;
        prod = mag1 * mag2;
        acc = {1'b0, dev_sum} + {1'b0, prod};
        dev_sum = acc[64] ? '1 : acc[63:0];

        r.change_found = 1'b0;
        r.position = seen_count[POS_W-1:0];
        r.upper_stat = cusum_up;
        r.lower_stat = cusum_dn;

        if (seen_count > arm_pos)
        begin
            var_q = dev_sum / {32'b0, run_len};
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= var_q)
                    root = trial;
            end
            allow = ({32'b0, k_cfg} * root) >> 16;
            if (allow > ALLOW_CAP)
                allow = ALLOW_CAP;
            d = xs - mean_q;
            s_up = longint'(cusum_up) + d - longint'(allow);
            s_dn = longint'(cusum_dn) - d - longint'(allow);
            cusum_up = clamp_stat(s_up);
            cusum_dn = clamp_stat(s_dn);
            r.upper_stat = cusum_up;
            r.lower_stat = cusum_dn;
            if (cusum_up > h_cfg || cusum_dn > h_cfg)
            begin
                r.change_found = 1'b1;
                next_arm = {1'b0, seen_count} + hold_cfg;
                arm_pos = next_arm[COUNT_W] ? '1 : next_arm[COUNT_W-1:0];
                mean_q = '0;
                dev_sum = '0;
                cusum_up = '0;
                cusum_dn = '0;
                run_len = '0;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic push_item(logic signed [SAMPLE_W-1:0] value, logic restart);
        sample_beat_t beat;
        beat.value = value;
        beat.restart = restart;
        sample_backlog.insert(sample_backlog.size(), beat);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ALLOWANCE_K: k_cfg = data;
            CFG_THRESHOLD:   h_cfg = data;
            CFG_HOLDOFF:     hold_cfg = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        while (sample_backlog.size() != 0 || smp.valid || cusum_due.size() != 0)
            @(negedge clk);
    endtask

    // mostly level-shift sequences with noise, the rest wild full-range beats
    task automatic queue_mix(int total, int wild_pct);
        int left, len, cut, amp, base, shift;
        logic signed [SAMPLE_W-1:0] v;
        left = total;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < wild_pct)
            begin
                case ($urandom_range(0, 2))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    default: v = $urandom;
                endcase
                push_item(v, $urandom_range(0, 7) == 0);
                left--;
            end
            else
            begin
                len = $urandom_range(6, 40);
                cut = $urandom_range(1, len);
                amp = 1 << $urandom_range(2, 18);
                base = (int'($urandom_range(0, 2000)) - 1000) <<< 14;
                shift = (int'($urandom_range(0, 40)) - 20) * amp;
                for (int i = 0; i < len && left > 0; i++)
                begin
                    v = base + (i >= cut ? shift : 0) + int'($urandom_range(0, 2 * amp)) - amp;
                    push_item(v, i == 0);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (smp.valid && smp.ready)
            begin
                cusum_due.insert(cusum_due.size(),
                                 advance_cusum(smp.sample_value, smp.new_sequence));
                accepted_count <= accepted_count + 1;
            end
            if (!smp.valid || smp.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    smp.valid <= 1'b0;
                end
                else if (sample_backlog.size() != 0)
                begin
                    next_beat = sample_backlog.pop_front();
                    smp.valid <= 1'b1;
                    smp.sample_value <= next_beat.value;
                    smp.new_sequence <= next_beat.restart;
                    if (!steady_tail && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 5);
                end
                else
                begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!hold_done && accepted_count == HOLD_AT)
        begin
            backpressure_left <= HOLD_SPAN;
            hold_done <= 1'b1;
        end
        else if (backpressure_left != 0)
        begin
            backpressure_left <= backpressure_left - 1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (cusum_due.size() == 0)
                begin
                    flag_mismatch($sformatf("result beat at position %0d with nothing expected",
                                            res.position));
                end
                else
                begin
                    want = cusum_due.pop_front();
                    if (res.change_found !== want.change_found)
                        flag_mismatch($sformatf("pos %0d change_found %b, want %b",
                                                want.position, res.change_found,
                                                want.change_found));
                    if (res.position !== want.position)
                        flag_mismatch($sformatf("position %0d, want %0d",
                                                res.position, want.position));
                    if (res.upper_stat !== want.upper_stat)
                        flag_mismatch($sformatf("pos %0d upper_stat %h, want %h",
                                                want.position, res.upper_stat,
                                                want.upper_stat));
                    if (res.lower_stat !== want.lower_stat)
                        flag_mismatch($sformatf("pos %0d lower_stat %h, want %h",
                                                want.position, res.lower_stat,
                                                want.lower_stat));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res.ready <= 1'b0;
            end
            else if (!steady_tail && $urandom_range(0, 4) == 0)
            begin
                stall_left <= $urandom_range(0, 4);
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= (backpressure_left == 0);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        smp.valid = 1'b0;
        smp.sample_value = '0;
        smp.new_sequence = 1'b0;
        res.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // default settings: field extremes, upward and downward shifts
        @(negedge clk);
        push_item(32'sd0, 1'b1);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'sd0, 1'b0);
        push_item(32'sh0001_0000, 1'b1);
        repeat (6) push_item(32'sh0001_0000, 1'b0);
        repeat (4) push_item(32'sh0014_0000, 1'b0);
        push_item(32'sh0005_0000, 1'b1);
        repeat (4) push_item(32'sh0005_0000, 1'b0);
        repeat (3) push_item(-32'sh001E_0000, 1'b0);
        push_item(32'sd0, 1'b1);
        drain();

        // zero slack and threshold; holdoff change mid-sequence keeps the arm point
        write_reg(CFG_ALLOWANCE_K, '0);
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_HOLDOFF, '0);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        @(negedge clk);
        repeat (6) push_item(32'sh0003_0000 + int'($urandom_range(0, 65535)), 1'b0);
        queue_mix(250, 15);
        drain();

        // maximum slack and threshold with wild beats
        write_reg(CFG_ALLOWANCE_K, '1);
        write_reg(CFG_THRESHOLD, '1);
        write_reg(CFG_HOLDOFF, 10'd2);
        @(negedge clk);
        queue_mix(150, 60);
        drain();

        write_reg(CFG_HOLDOFF, '1);
        write_reg(CFG_ALLOWANCE_K, $urandom_range(0, 1 << 18));
        write_reg(CFG_THRESHOLD, $urandom_range(1 << 16, 1 << 22));
        @(negedge clk);
        queue_mix(100, 10);
        drain();

        repeat (4)
        begin
            write_reg(CFG_ALLOWANCE_K, $urandom_range(0, 1 << 18));
            write_reg(CFG_THRESHOLD, $urandom_range(1 << 16, 1 << 22));
            write_reg(CFG_HOLDOFF, $urandom_range(0, 20));
            @(negedge clk);
            queue_mix(200, 15);
            drain();
        end

        // closing stretch at full rate
        steady_tail = 1'b1;
        write_reg(CFG_ALLOWANCE_K, K_DEFAULT);
        write_reg(CFG_THRESHOLD, H_DEFAULT);
        write_reg(CFG_HOLDOFF, HOLD_DEFAULT);
        @(negedge clk);
        queue_mix(300, 10);
        drain();

        repeat (END_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ccd_pkg.sv
rtl/core/ccd_channels.sv
rtl/core/ccd_iter_unit.sv
rtl/core/cusum_change_detector.sv
bench/tb_cusum_change_detector.sv
